/* rtl/ceb_pkg.sv */
package ceb_pkg;

    // field and datapath widths
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int MAG_W     = COORD_W;
    localparam int DOTM_W    = 2 * COORD_W;
    localparam int HALF_W    = DOTM_W / 2;
    localparam int DEN_W     = 2 * COORD_W + 1;
    localparam int NUM_W     = DOTM_W + MAG_W;
    localparam int QW        = COORD_W + 1;
    localparam int PROJ_W    = QW + 1;
    localparam int RES_W     = QW + 2;

    // pipeline depths
    localparam int FRONT_LAT = 6;
    localparam int DIV_LAT   = QW + 1;
    localparam int BACK_LAT  = 2;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

    // per-item data that travels beside the divider
    typedef struct packed {
        logic signed [COORD_W-1:0] vx1;
        logic signed [COORD_W-1:0] vy1;
        logic signed [COORD_W-1:0] vx2;
        logic signed [COORD_W-1:0] vy2;
        logic                      coin;
        logic [3:0]                neg;
    } t_side;

    // saturate to the field range, clip flag in the top bit
    function automatic logic [COORD_W:0] sat_clip(input logic signed [RES_W-1:0] v);
        logic in_range;
        logic [COORD_W-1:0] val;
        in_range = (v[RES_W-1:COORD_W-1] == {(RES_W-COORD_W+1){1'b0}}) ||
                   (v[RES_W-1:COORD_W-1] == {(RES_W-COORD_W+1){1'b1}});
        if (in_range) begin
            val = v[COORD_W-1:0];
        end else if (v[RES_W-1]) begin
            val = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            val = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return {!in_range, val};
    endfunction

endpackage

/* rtl/ceb_front.sv */
module ceb_front (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_y,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_vx,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_vy,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_y,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_vx,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_vy,
    output logic [3:0][ceb_pkg::NUM_W-1:0]        o_num,
    output logic [ceb_pkg::DEN_W-1:0]             o_den,
    output ceb_pkg::t_side                        o_side
);
    import ceb_pkg::*;

    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    t_side                    r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;

    logic signed [DIFF_W-1:0] r2_dx, r2_dy;
    logic signed [PROD_W-1:0] r2_p1x, r2_p1y, r2_p2x, r2_p2y, r2_dxx, r2_dyy;

    logic signed [PROD_W-1:0] n3_dot1, n3_dot2, n3_den;
    logic signed [PROD_W-1:0] r3_dot1, r3_dot2;
    logic [DEN_W-1:0]         r3_den, r4_den, r5_den, r6_den;
    logic [MAG_W-1:0]         r3_mx, r3_my, r4_mx, r4_my;
    logic                     r3_sx, r3_sy;

    logic [DOTM_W-1:0]        r4_dm1, r4_dm2;

    logic [DOTM_W-1:0]        w_dm   [4];
    logic [MAG_W-1:0]         w_dc   [4];
    logic [DOTM_W-1:0]        r5_lo  [4];
    logic [DOTM_W-1:0]        r5_hi  [4];
    logic [NUM_W-1:0]         r6_num [4];

    // stage 1: centre differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx        <= DIFF_W'(i_second_x) - DIFF_W'(i_first_x);
            r1_dy        <= DIFF_W'(i_second_y) - DIFF_W'(i_first_y);
            r1_side.vx1  <= i_first_vx;
            r1_side.vy1  <= i_first_vy;
            r1_side.vx2  <= i_second_vx;
            r1_side.vy2  <= i_second_vy;
            r1_side.coin <= 1'b0;
            r1_side.neg  <= 4'b0000;
        end
    end

    // stage 2: products for dot products and squared length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dx        <= r1_dx;
            r2_dy        <= r1_dy;
            r2_p1x       <= r1_side.vx1 * r1_dx;
            r2_p1y       <= r1_side.vy1 * r1_dy;
            r2_p2x       <= r1_side.vx2 * r1_dx;
            r2_p2y       <= r1_side.vy2 * r1_dy;
            r2_dxx       <= r1_dx * r1_dx;
            r2_dyy       <= r1_dy * r1_dy;
            r2_side      <= {r1_side.vx1, r1_side.vy1, r1_side.vx2, r1_side.vy2,
                             (r1_dx == '0) && (r1_dy == '0), r1_side.neg};
        end
    end

    // stage 3: sums, direction magnitudes
    assign n3_dot1 = r2_p1x + r2_p1y;
    assign n3_dot2 = r2_p2x + r2_p2y;
    assign n3_den  = r2_dxx + r2_dyy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dot1 <= n3_dot1;
            r3_dot2 <= n3_dot2;
            r3_den  <= n3_den[DEN_W-1:0];
            r3_mx   <= MAG_W'(r2_dx[DIFF_W-1] ? -r2_dx : r2_dx);
            r3_my   <= MAG_W'(r2_dy[DIFF_W-1] ? -r2_dy : r2_dy);
            r3_sx   <= r2_dx[DIFF_W-1];
            r3_sy   <= r2_dy[DIFF_W-1];
            r3_side <= r2_side;
        end
    end

    // stage 4: dot magnitudes and projection signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dm1      <= DOTM_W'(r3_dot1[PROD_W-1] ? -r3_dot1 : r3_dot1);
            r4_dm2      <= DOTM_W'(r3_dot2[PROD_W-1] ? -r3_dot2 : r3_dot2);
            r4_mx       <= r3_mx;
            r4_my       <= r3_my;
            r4_den      <= r3_den;
            r4_side     <= {r3_side.vx1, r3_side.vy1, r3_side.vx2, r3_side.vy2, r3_side.coin,
                            r3_dot2[PROD_W-1] ^ r3_sy, r3_dot2[PROD_W-1] ^ r3_sx,
                            r3_dot1[PROD_W-1] ^ r3_sy, r3_dot1[PROD_W-1] ^ r3_sx};
        end
    end

    // stage 5: numerator partial products, order px1 py1 px2 py2
    assign w_dm[0] = r4_dm1;
    assign w_dm[1] = r4_dm1;
    assign w_dm[2] = r4_dm2;
    assign w_dm[3] = r4_dm2;
    assign w_dc[0] = r4_mx;
    assign w_dc[1] = r4_my;
    assign w_dc[2] = r4_mx;
    assign w_dc[3] = r4_my;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r5_lo[k] <= w_dm[k][HALF_W-1:0] * w_dc[k];
                r5_hi[k] <= w_dm[k][DOTM_W-1:HALF_W] * w_dc[k];
            end
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // stage 6: join partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r6_num[k] <= {r5_hi[k], {HALF_W{1'b0}}} + NUM_W'(r5_lo[k]);
            end
            r6_den  <= r5_den;
            r6_side <= r5_side;
        end
    end

    assign o_num[0] = r6_num[0];
    assign o_num[1] = r6_num[1];
    assign o_num[2] = r6_num[2];
    assign o_num[3] = r6_num[3];
    assign o_den    = r6_den;
    assign o_side   = r6_side;

endmodule

/* rtl/ceb_div.sv */
module ceb_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ceb_pkg::NUM_W-1:0]    i_num,
    input  logic [ceb_pkg::DEN_W-1:0]    i_den,
    output logic [ceb_pkg::QW-1:0]       o_q
);
    import ceb_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_lo  [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [QW-1:0]    r_qr;

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [REM_W-1:0] w_rem_in;
        logic [QW-1:0]    w_lo_in;
        logic [QW-1:0]    w_q_in;
        logic [DEN_W-1:0] w_den_in;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = REM_W'(i_num[NUM_W-1:QW]);
            assign w_lo_in  = i_num[QW-1:0];
            assign w_q_in   = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_lo_in  = r_lo[k-1];
            assign w_q_in   = r_q[k-1];
            assign w_den_in = r_den[k-1];
        end

        assign w_trial = {w_rem_in[REM_W-2:0], w_lo_in[QW-1]};
        assign w_ge    = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_trial - {1'b0, w_den_in} : w_trial;
                r_lo[k]  <= {w_lo_in[QW-2:0], 1'b0};
                r_q[k]   <= {w_q_in[QW-2:0], w_ge};
                r_den[k] <= w_den_in;
            end
        end
    end

    // round to nearest, ties away from zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr <= r_q[QW-1] +
                    QW'({r_rem[QW-1], 1'b0} >= {2'b00, r_den[QW-1]});
        end
    end

    assign o_q = r_qr;

endmodule

/* rtl/circle_elastic_bounce.sv */
// Elastic bounce of two equal-mass circles: the velocity parts along the line of
// centres are exchanged, the parts across it kept, in signed Q16.8. One circle pair
// is taken every cycle while the output is not stalled; the pipeline depth is set
// mostly by the four 25-stage restoring dividers (one quotient bit per stage) that
// form the projections. Coinciding centres pass the velocities through with
// o_centres_coincide set; out-of-range results saturate and raise o_clipped.
// A stall at the output holds the whole pipeline.
module circle_elastic_bounce (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_y,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_vx,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_first_vy,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_y,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_vx,
    input  logic signed [ceb_pkg::COORD_W-1:0]    i_second_vy,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ceb_pkg::COORD_W-1:0]    o_new_first_vx,
    output logic signed [ceb_pkg::COORD_W-1:0]    o_new_first_vy,
    output logic signed [ceb_pkg::COORD_W-1:0]    o_new_second_vx,
    output logic signed [ceb_pkg::COORD_W-1:0]    o_new_second_vy,
    output logic                                  o_centres_coincide,
    output logic                                  o_clipped
);
    import ceb_pkg::*;

    logic                     w_en;
    logic [TOTAL_LAT-1:0]     r_vld;

    logic [3:0][NUM_W-1:0]    w_num;
    logic [DEN_W-1:0]         w_den;
    t_side                    w_fside;
    logic [QW-1:0]            w_q [4];

    t_side                    r_dside [DIV_LAT];
    t_side                    r_f1_side;
    logic signed [PROJ_W-1:0] r_p [4];

    logic signed [RES_W-1:0]  w_n [4];
    logic [COORD_W:0]         w_s [4];

    logic signed [COORD_W-1:0] r_o_vx1, r_o_vy1, r_o_vx2, r_o_vy2;
    logic                      r_o_coin, r_o_clip;

    // whole pipeline moves unless the output register is full and stalled
    assign w_en    = !r_vld[TOTAL_LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[TOTAL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_valid};
        end
    end

    // differences, dot products and numerators
    ceb_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_first_vx  (i_first_vx),
        .i_first_vy  (i_first_vy),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .i_second_vx (i_second_vx),
        .i_second_vy (i_second_vy),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_side      (w_fside)
    );

    // one divider per projection component
    for (genvar k = 0; k < 4; k++) begin : g_div
        ceb_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[k]),
            .i_den (w_den),
            .o_q   (w_q[k])
        );
    end

    // side data kept in step with the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= w_fside;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // apply projection signs
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= r_dside[DIV_LAT-1].neg[k] ? -PROJ_W'(w_q[k]) : PROJ_W'(w_q[k]);
            end
            r_f1_side <= r_dside[DIV_LAT-1];
        end
    end

    // exchange normal parts (coinciding centres pass through), then saturate
    always_comb begin
        if (r_f1_side.coin) begin
            w_n[0] = RES_W'(r_f1_side.vx1);
            w_n[1] = RES_W'(r_f1_side.vy1);
            w_n[2] = RES_W'(r_f1_side.vx2);
            w_n[3] = RES_W'(r_f1_side.vy2);
        end else begin
            w_n[0] = RES_W'(r_f1_side.vx1) - RES_W'(r_p[0]) + RES_W'(r_p[2]);
            w_n[1] = RES_W'(r_f1_side.vy1) - RES_W'(r_p[1]) + RES_W'(r_p[3]);
            w_n[2] = RES_W'(r_f1_side.vx2) - RES_W'(r_p[2]) + RES_W'(r_p[0]);
            w_n[3] = RES_W'(r_f1_side.vy2) - RES_W'(r_p[3]) + RES_W'(r_p[1]);
        end
        for (int k = 0; k < 4; k++) begin
            w_s[k] = sat_clip(w_n[k]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_vx1  <= w_s[0][COORD_W-1:0];
            r_o_vy1  <= w_s[1][COORD_W-1:0];
            r_o_vx2  <= w_s[2][COORD_W-1:0];
            r_o_vy2  <= w_s[3][COORD_W-1:0];
            r_o_coin <= r_f1_side.coin;
            r_o_clip <= w_s[0][COORD_W] | w_s[1][COORD_W] | w_s[2][COORD_W] | w_s[3][COORD_W];
        end
    end

    assign o_new_first_vx     = r_o_vx1;
    assign o_new_first_vy     = r_o_vy1;
    assign o_new_second_vx    = r_o_vx2;
    assign o_new_second_vy    = r_o_vy2;
    assign o_centres_coincide = r_o_coin;
    assign o_clipped          = r_o_clip;

`ifndef ASSERT_OFF
    // coinciding centres pass velocities through, so nothing can saturate
    a_coin_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_centres_coincide |-> !o_clipped)
        else $error("clip flagged with coinciding centres");

    // a stall freezes every valid bit in the pipeline
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule
